FILE: rtl/mfn_pkg.sv
// Package for the mixed fraction normalizer core.
// Holds the status word shared by the divider, the GCD unit and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mfn_pkg;

   // Status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } mfn_unit_status_type;

endpackage

FILE: rtl/mixed_fraction_normalizer_core.sv
// Mixed fraction normalizer: one word in, one word out, W = VALUE_BITS.
// Zero denominator: result strobe in the cycle after acceptance.
// Otherwise: one divide, a binary GCD, then two divides by the GCD; the three
// divides share one restoring divider.
// Busy stays high until the result strobe; the receiver cannot stall it.
// Synchronous reset returns the sequencer to idle and clears the strobe.
`timescale 1ns / 1ps

module mixed_fraction_normalizer_core import mfn_pkg::*; #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_whole_in,
   input  logic [VALUE_BITS-1:0] req_numer_in,
   input  logic [VALUE_BITS-1:0] req_denom_in,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_whole_out,
   output logic [VALUE_BITS-1:0] rsp_numer_out,
   output logic [VALUE_BITS-1:0] rsp_denom_out,
   output logic                  rsp_whole_saturated
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_QUOT,
      ST_GCD,
      ST_DIV_NUMER,
      ST_DIV_DENOM
   } state_type;

   state_type             state_ff, state_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] whole_ff, whole_in;
   logic [VALUE_BITS-1:0] denom_ff, denom_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] gcd_ff, gcd_in;
   logic [VALUE_BITS-1:0] whole_out_ff, whole_out_in;
   logic [VALUE_BITS-1:0] numer_out_ff, numer_out_in;
   logic [VALUE_BITS-1:0] denom_out_ff, denom_out_in;
   logic                  sat_ff, sat_in;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   mfn_unit_status_type   div_status;
   logic [VALUE_BITS-1:0] div_quot;
   logic [VALUE_BITS-1:0] div_rem;

   logic                  gcd_start;
   mfn_unit_status_type   gcd_status;
   logic [VALUE_BITS-1:0] gcd_result;

   logic [VALUE_BITS:0]   whole_sum;
   logic                  accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign whole_sum = {1'b0, whole_ff} + {1'b0, div_quot};

   // Sequence the shared divider and the GCD unit
   always_comb begin
      state_in     = state_ff;
      valid_in     = 1'b0;
      whole_in     = whole_ff;
      denom_in     = denom_ff;
      rem_in       = rem_ff;
      gcd_in       = gcd_ff;
      whole_out_in = whole_out_ff;
      numer_out_in = numer_out_ff;
      denom_out_in = denom_out_ff;
      sat_in       = sat_ff;
      div_start    = 1'b0;
      div_dividend = req_numer_in;
      div_divisor  = req_denom_in;
      gcd_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               whole_in = req_whole_in;
               denom_in = req_denom_in;
               if (req_denom_in == '0) begin
                  // Pass the word through unchanged
                  whole_out_in = req_whole_in;
                  numer_out_in = req_numer_in;
                  denom_out_in = req_denom_in;
                  sat_in       = 1'b0;
                  valid_in     = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_QUOT;
               end
            end
         end
         ST_DIV_QUOT: begin
            if (div_status.done) begin
               // Fold the quotient into the whole part, clamp on carry
               if (whole_sum[VALUE_BITS]) begin
                  whole_out_in = '1;
                  sat_in       = 1'b1;
               end else begin
                  whole_out_in = whole_sum[VALUE_BITS-1:0];
                  sat_in       = 1'b0;
               end
               rem_in    = div_rem;
               gcd_start = 1'b1;
               state_in  = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_status.done) begin
               gcd_in       = gcd_result;
               div_start    = 1'b1;
               div_dividend = rem_ff;
               div_divisor  = gcd_result;
               state_in     = ST_DIV_NUMER;
            end
         end
         ST_DIV_NUMER: begin
            div_dividend = rem_ff;
            div_divisor  = gcd_ff;
            if (div_status.done) begin
               numer_out_in = div_quot;
               div_start    = 1'b1;
               div_dividend = denom_ff;
               state_in     = ST_DIV_DENOM;
            end
         end
         ST_DIV_DENOM: begin
            div_dividend = denom_ff;
            div_divisor  = gcd_ff;
            if (div_status.done) begin
               denom_out_in = div_quot;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      whole_ff     <= whole_in;
      denom_ff     <= denom_in;
      rem_ff       <= rem_in;
      gcd_ff       <= gcd_in;
      whole_out_ff <= whole_out_in;
      numer_out_ff <= numer_out_in;
      denom_out_ff <= denom_out_in;
      sat_ff       <= sat_in;
   end

   mfn_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   mfn_gcd #(
      .VALUE_BITS (VALUE_BITS)
   ) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .a_init (div_rem),
      .b_init (denom_ff),
      .status (gcd_status),
      .result (gcd_result)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = valid_ff;
   assign rsp_whole_out       = whole_out_ff;
   assign rsp_numer_out       = numer_out_ff;
   assign rsp_denom_out       = denom_out_ff;
   assign rsp_whole_saturated = sat_ff;

   // An accepted word is either answered at once or keeps the core busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff || busy)
      else $error("accepted word dropped");

   // The result strobe comes only with the sequencer back in idle
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while busy");

   // A clamped whole part reads as all ones
   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff && sat_ff |-> whole_out_ff == '1)
      else $error("saturated whole part not clamped");

   // A reduced fraction has a nonzero denominator
   a_reduced_denom: assert property (@(posedge clock) disable iff (reset)
      valid_ff && $past(state_ff == ST_DIV_DENOM) |-> denom_out_ff != '0)
      else $error("reduced denominator is zero");

   // Both arithmetic units sit idle while the sequencer waits for a word
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_status.busy && !gcd_status.busy)
      else $error("arithmetic unit busy in idle");

endmodule

FILE: rtl/mfn_divider.sv
// Restoring divider, one quotient bit per cycle, for the normalizer core.
// Depends on mfn_pkg for the unit status word.
`timescale 1ns / 1ps

module mfn_divider import mfn_pkg::*; #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output mfn_unit_status_type   status,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   // Shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start && !busy_ff) begin
         busy_in    = 1'b1;
         count_in   = LAST_STEP;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // Keep the difference when it did not borrow
         if (!diff[VALUE_BITS]) begin
            rem_in = diff[VALUE_BITS-1:0];
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         quot_in = {quot_ff[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;
   assign remainder   = rem_ff;

   // A finished division leaves a remainder below a nonzero divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff && (divisor_ff != '0) |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   // A start on an idle unit makes it busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff && !done_ff)
      else $error("divider did not start");

   // Done is a single pulse after the busy phase
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without busy phase");

endmodule

FILE: rtl/mfn_gcd.sv
// Binary GCD unit: one shift or subtract step per cycle.
// Depends on mfn_pkg for the unit status word.
`timescale 1ns / 1ps

module mfn_gcd import mfn_pkg::*; #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] a_init,
   input  logic [VALUE_BITS-1:0] b_init,
   output mfn_unit_status_type   status,
   output logic [VALUE_BITS-1:0] result
);

   localparam int SH_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [SH_W-1:0]       shift_ff, shift_in;
   logic [VALUE_BITS-1:0] result_ff, result_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      a_in      = a_ff;
      b_in      = b_ff;
      shift_in  = shift_ff;
      result_in = result_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         a_in     = a_init;
         b_in     = b_init;
         shift_in = '0;
      end else if (busy_ff) begin
         if (a_ff == '0) begin
            // Other operand times the common power of two
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = b_ff << shift_ff;
         end else if (b_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = a_ff << shift_ff;
         end else if (!a_ff[0] && !b_ff[0]) begin
            // Pull out a common factor of two
            a_in     = a_ff >> 1;
            b_in     = b_ff >> 1;
            shift_in = shift_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      shift_ff  <= shift_in;
      result_ff <= result_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = result_ff;

   // Operands never both reach zero while the unit runs on a nonzero pair
   a_not_both_zero: assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(busy_ff) |-> (a_ff != '0) || (b_ff != '0))
      else $error("gcd operands both zero");

   // Done is a single pulse after the busy phase
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("gcd done without busy phase");

   // A start on an idle unit makes it busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff)
      else $error("gcd did not start");

endmodule

FILE: verif/mixed_fraction_normalizer_core_tb.sv
// Testbench for mixed_fraction_normalizer_core: directed table, then random mixed numbers.
// Every result is checked against a queued answer, from the table or a local normalizer model.
// Depends on rtl/mfn_pkg.sv and rtl/mixed_fraction_normalizer_core.sv.
`timescale 1ns / 1ps

module mixed_fraction_normalizer_core_tb;
   import mfn_pkg::*;

   localparam int VALUE_BITS   = 31;
   localparam int RANDOM_WORDS = 800;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 250;

   typedef logic [VALUE_BITS-1:0] value_type;
   localparam value_type VALUE_MAX = '1;

   typedef struct {
      value_type whole;
      value_type numer;
      value_type denom;
      logic      sat;
   } mixed_num_type;

   // One row of the directed table; typed rows carry their own answer
   typedef struct {
      value_type     whole;
      value_type     numer;
      value_type     denom;
      bit            typed;
      mixed_num_type answer;
   } table_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   value_type req_whole_in = '0;
   value_type req_numer_in = '0;
   value_type req_denom_in = '0;
   logic      rsp_valid;
   value_type rsp_whole_out;
   value_type rsp_numer_out;
   value_type rsp_denom_out;
   logic      rsp_whole_saturated;

   mixed_num_type expected_q[$];
   table_row_type directed_rows[$];
   int mismatch_count = 0;
   int words_sent     = 0;
   int results_seen   = 0;
   int sat_seen       = 0;
   int zero_denom     = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;

   mixed_fraction_normalizer_core #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_whole_in       (req_whole_in),
      .req_numer_in       (req_numer_in),
      .req_denom_in       (req_denom_in),
      .rsp_valid          (rsp_valid),
      .rsp_whole_out      (rsp_whole_out),
      .rsp_numer_out      (rsp_numer_out),
      .rsp_denom_out      (rsp_denom_out),
      .rsp_whole_saturated(rsp_whole_saturated)
   );

   always #5 clock = ~clock;

   // Fold the quotient into the whole part, then reduce the remainder by the GCD
   function automatic mixed_num_type normalize_mixed(value_type w, value_type n,
                                                     value_type d);
      mixed_num_type r;
      logic [63:0] quot;
      logic [63:0] rem;
      logic [63:0] sum;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      r.whole = w;
      r.numer = n;
      r.denom = d;
      r.sat   = 1'b0;
      if (d != '0) begin
         quot = 64'(n) / 64'(d);
         rem  = 64'(n) % 64'(d);
         sum  = 64'(w) + quot;
         if (sum > 64'(VALUE_MAX)) begin
            sum   = 64'(VALUE_MAX);
            r.sat = 1'b1;
         end
         r.whole = sum[VALUE_BITS-1:0];
         a = rem;
         b = 64'(d);
         while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
         end
         r.numer = value_type'(rem / a);
         r.denom = value_type'(64'(d) / a);
      end
      return r;
   endfunction

   function automatic table_row_type make_row(value_type w, value_type n, value_type d,
                                              bit typed, value_type ew, value_type en,
                                              value_type ed, logic es);
      table_row_type row;
      row.whole        = w;
      row.numer        = n;
      row.denom        = d;
      row.typed        = typed;
      row.answer.whole = ew;
      row.answer.numer = en;
      row.answer.denom = ed;
      row.answer.sat   = es;
      return row;
   endfunction

   // Random value with a random number of significant bits
   function automatic value_type rand_span();
      value_type v;
      v = value_type'($urandom);
      return v >> $urandom_range(0, VALUE_BITS - 1);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Present one word, hold it until accepted, then queue its answer
   task automatic drive_word(input value_type w, input value_type n, input value_type d,
                             input bit typed, input mixed_num_type answer);
      start        <= 1'b1;
      req_whole_in <= w;
      req_numer_in <= n;
      req_denom_in <= d;
      do @(posedge clock); while (busy);
      if (typed) begin
         expected_q.push_back(answer);
      end else begin
         expected_q.push_back(normalize_mixed(w, n, d));
      end
      words_sent++;
   endtask

   // Close a burst with a random gap, or keep going back to back
   task automatic sender_idle();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off the sender until every queued answer has been matched
   task automatic drain_results();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Compare each strobed result against the oldest answer
   always @(posedge clock) begin
      mixed_num_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result whole=%0d numer=%0d denom=%0d sat=%0b",
                                    rsp_whole_out, rsp_numer_out, rsp_denom_out,
                                    rsp_whole_saturated));
         end else begin
            exp_r = expected_q.pop_front();
            results_seen++;
            if (exp_r.sat) sat_seen++;
            if (rsp_whole_out !== exp_r.whole || rsp_numer_out !== exp_r.numer ||
                rsp_denom_out !== exp_r.denom || rsp_whole_saturated !== exp_r.sat) begin
               note_mismatch($sformatf(
                  "result %0d: expected %0d %0d/%0d sat=%0b, got %0d %0d/%0d sat=%0b",
                  results_seen, exp_r.whole, exp_r.numer, exp_r.denom, exp_r.sat,
                  rsp_whole_out, rsp_numer_out, rsp_denom_out, rsp_whole_saturated));
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d answers pending",
                     STALL_LIMIT, expected_q.size());
            $display("mixed_fraction_normalizer_core test failed");
            $finish;
         end
      end
   end

   initial begin
      mixed_num_type none;
      value_type w;
      value_type n;
      value_type d;
      value_type g;
      int kind;
      none = '{default: '0};

      // Directed table: typed answers for pass-through, extremes and saturation
      directed_rows.push_back(make_row(0, 0, 0, 1, 0, 0, 0, 0));
      directed_rows.push_back(make_row(VALUE_MAX, VALUE_MAX, 0, 1, VALUE_MAX, VALUE_MAX, 0, 0));
      directed_rows.push_back(make_row(12345, 777, 0, 1, 12345, 777, 0, 0));
      directed_rows.push_back(make_row(0, 0, 1, 1, 0, 0, 1, 0));
      directed_rows.push_back(make_row(0, 0, VALUE_MAX, 1, 0, 0, 1, 0));
      directed_rows.push_back(make_row(VALUE_MAX, VALUE_MAX, 1, 1, VALUE_MAX, 0, 1, 1));
      directed_rows.push_back(make_row(VALUE_MAX, 1, 1, 1, VALUE_MAX, 0, 1, 1));
      directed_rows.push_back(make_row(VALUE_MAX, 0, 1, 1, VALUE_MAX, 0, 1, 0));
      directed_rows.push_back(make_row(VALUE_MAX - 1, 1, 1, 1, VALUE_MAX, 0, 1, 0));
      directed_rows.push_back(make_row(0, VALUE_MAX, 1, 1, VALUE_MAX, 0, 1, 0));
      directed_rows.push_back(make_row(0, VALUE_MAX, VALUE_MAX, 1, 1, 0, 1, 0));
      directed_rows.push_back(make_row(0, 1, VALUE_MAX, 1, 0, 1, VALUE_MAX, 0));
      directed_rows.push_back(make_row(0, VALUE_MAX - 1, VALUE_MAX, 1,
                                       0, VALUE_MAX - 1, VALUE_MAX, 0));
      // The rest go through the model
      directed_rows.push_back(make_row(5, 6, 4, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 12, 18, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(3, 100, 7, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 31'h4000_0000, 31'h6000_0000, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 31'h5555_5555, 31'h2AAA_AAAA, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1, 3 * 7 * 11 * 13, 7 * 11 * 13 * 17, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(VALUE_MAX, 5, 10, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(10, 31'h4000_0000, 31'h2000_0000, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 1, 2, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(31'h2AAA_AAAA, 31'h5555_5555, 3, 0, 0, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].denom == '0) zero_denom++;
         drive_word(directed_rows[i].whole, directed_rows[i].numer, directed_rows[i].denom,
                    directed_rows[i].typed, directed_rows[i].answer);
         sender_idle();
      end
      drain_results();

      // Random mixed numbers, weighted toward cases that exercise the GCD and the clamp
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               w = value_type'($urandom);
               n = value_type'($urandom);
               d = '0;
            end
            1: begin
               w = value_type'($urandom);
               n = value_type'($urandom);
               d = value_type'($urandom);
            end
            2: begin
               // shared factor between numerator and denominator
               g = value_type'($urandom_range(1, 4096));
               w = rand_span();
               n = value_type'($urandom_range(0, (1 << 19) - 1)) * g;
               d = value_type'($urandom_range(1, (1 << 19) - 1)) * g;
            end
            3: begin
               // whole part close to the top, clamps often
               w = VALUE_MAX - value_type'($urandom_range(0, 5000));
               n = rand_span();
               d = value_type'($urandom_range(1, 50));
            end
            4: begin
               // numerator an exact multiple of the denominator
               w = rand_span();
               d = value_type'($urandom_range(1, 65535));
               n = d * value_type'($urandom_range(0, 32767));
            end
            5: begin
               w = value_type'($urandom_range(0, 255));
               n = value_type'($urandom_range(0, 255));
               d = value_type'($urandom_range(0, 255));
            end
            default: begin
               w = rand_span();
               n = rand_span();
               d = rand_span();
            end
         endcase
         if (d == '0) zero_denom++;
         drive_word(w, n, d, 1'b0, none);
         if (i == RANDOM_WORDS / 2) begin
            drain_results();
         end else begin
            sender_idle();
         end
      end

      // Let everything come back, then give the core time to misbehave
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         note_mismatch($sformatf("%0d answers never arrived", expected_q.size()));
      end

      $display("sent %0d words (%0d with zero denominator), checked %0d results",
               words_sent, zero_denom, results_seen);
      $display("%0d results saturated the whole part, %0d mismatches",
               sat_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("mixed_fraction_normalizer_core test passed");
      end else begin
         $display("mixed_fraction_normalizer_core test failed");
      end
      $finish;
   end

endmodule
